// ===== rtl/core/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types, constants and the square root step of the time displace unit
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  localparam int DEF_MAX_FRAMES   = 64;
  localparam int DEF_IMAGE_WIDTH  = 256;
  localparam int DEF_IMAGE_HEIGHT = 256;

  // slot fields are sized for the largest supported ring
  localparam int SLOT_WMAX  = 10;
  localparam int DELAY_W    = 24;
  localparam int FRAC_W     = 12;
  localparam int IDX_W      = DELAY_W - FRAC_W;
  localparam int INV_W      = 15;
  localparam int SQ_W       = 25;
  localparam int ROOT_STEPS = 13;
  localparam int ROOT_W     = 13;

  localparam int FRONT_STAGES = ROOT_STEPS + 4;
  localparam int BACK_STAGES  = 5;
  localparam int MID_DEPTH    = FRONT_STAGES + 3;
  localparam int OUT_DEPTH    = BACK_STAGES + 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [1:0] MODE_HORIZ  = 2'd0;
  localparam logic [1:0] MODE_VERT   = 2'd1;
  localparam logic [1:0] MODE_RADIAL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SLIT_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 3'd4;

  localparam logic [INV_W-1:0] RST_INV_WIDTH   = 15'd910;
  localparam logic [6:0]       RST_FRAME_LIMIT = 7'd64;

  typedef struct packed {
    logic [1:0]       mode;
    logic [INV_W-1:0] inv;
    logic [7:0]       cx;
    logic [7:0]       cy;
    logic [6:0]       limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]           x;
    logic [7:0]           y;
    logic [23:0]          rgb;
    logic [SLOT_WMAX-1:0] head;
    logic [SLOT_WMAX-1:0] last;
    logic [DELAY_W-1:0]   delay;
  } mid_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  typedef struct packed {
    logic [SQ_W:0] rem;
    logic [SQ_W:0] root;
  } root_t;

  // one digit of the restoring square root
  function automatic root_t root_step(root_t a, logic [SQ_W:0] b);
    root_t         o;
    logic [SQ_W:0] t;
    t = a.root + b;
    if (a.rem >= t) begin
      o.rem  = a.rem - t;
      o.root = (a.root >> 1) + b;
    end else begin
      o.rem  = a.rem;
      o.root = a.root >> 1;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slit_scan_time_displace_unit.sv =====
// ----------------------------------------------------------------------------
// slit_scan_time_displace_unit
// slit-scan time displacement over a pixel stream with a frame history ring
// ----------------------------------------------------------------------------
// path: an accepted pixel passes the delay front with its square root
//   pipeline, then the back end with the frame store, to the result shown
// throughput: one pixel per cycle while full is low, set by the frame
//   store's one write and two read ports used once per pixel
// reset: synchronous, resets control registers, ring state and queues; the
//   frame store is not cleared
`default_nettype none

module slit_scan_time_displace_unit #(
  parameter int MAX_FRAMES   = ssd_pkg::DEF_MAX_FRAMES,
  parameter int IMAGE_WIDTH  = ssd_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = ssd_pkg::DEF_IMAGE_HEIGHT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [7:0]                       in_pixel_x,
  input  wire logic [7:0]                       in_pixel_y,
  input  wire logic [7:0]                       in_red,
  input  wire logic [7:0]                       in_green,
  input  wire logic [7:0]                       in_blue,
  input  wire logic                             in_start_of_frame,
  input  wire logic                             pop,
  output logic                                  empty,
  output logic [7:0]                            out_red,
  output logic [7:0]                            out_green,
  output logic [7:0]                            out_blue,
  input  wire logic                             cfg_we,
  input  wire logic [ssd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ssd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import ssd_pkg::*;

  cfg_t      cfg_r;
  mid_item_t f_data, m_data;
  out_item_t b_data, o_data;
  logic      f_push, m_pop, m_empty, b_push, o_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_RADIAL;
      cfg_r.inv   <= RST_INV_WIDTH;
      cfg_r.cx    <= '0;
      cfg_r.cy    <= '0;
      cfg_r.limit <= RST_FRAME_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLIT_MODE:   cfg_r.mode  <= cfg_wdata[1:0];
        CFG_INV_WIDTH:   cfg_r.inv   <= cfg_wdata[INV_W-1:0];
        CFG_CENTRE_X:    cfg_r.cx    <= cfg_wdata[7:0];
        CFG_CENTRE_Y:    cfg_r.cy    <= cfg_wdata[7:0];
        CFG_FRAME_LIMIT: cfg_r.limit <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  ssd_front #(
    .MAX_FRAMES   (MAX_FRAMES),
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .QDEPTH       (MID_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .pixel_x (in_pixel_x),
    .pixel_y (in_pixel_y),
    .rgb     ({in_red, in_green, in_blue}),
    .sof     (in_start_of_frame),
    .cfg     (cfg_r),
    .q_pop   (m_pop),
    .q_push  (f_push),
    .q_data  (f_data)
  );

  ssd_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_data),
    .pop   (m_pop),
    .dout  (m_data),
    .empty (m_empty)
  );

  ssd_back #(
    .MAX_FRAMES   (MAX_FRAMES),
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .ODEPTH       (OUT_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (m_empty),
    .q_data  (m_data),
    .q_pop   (m_pop),
    .o_pop   (o_pop),
    .o_push  (b_push),
    .o_data  (b_data)
  );

  assign o_pop = pop && !empty;

  ssd_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b_push),
    .din   (b_data),
    .pop   (o_pop),
    .dout  (o_data),
    .empty (empty)
  );

  assign out_red   = o_data.red;
  assign out_green = o_data.green;
  assign out_blue  = o_data.blue;

endmodule

`default_nettype wire

// ===== rtl/core/ssd_ram.sv =====
// ----------------------------------------------------------------------------
// ssd_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_ram #(
  parameter int     WIDTH = 24,
  parameter longint DEPTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]          wdata,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr_b,
  output logic      [WIDTH-1:0]          rdata_a,
  output logic      [WIDTH-1:0]          rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssd_fifo.sv =====
// ----------------------------------------------------------------------------
// ssd_fifo
// small register queue, head entry shown while not empty
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;

  assign dout  = mem_r[rp_r];
  assign empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == CNT_W'(DEPTH)))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue underflow");
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && empty) |=> !empty)
    else $error("pushed entry lost");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ssd_front.sv =====
// ----------------------------------------------------------------------------
// ssd_front
// accepts pixels, keeps the frame ring state and forms the frame delay
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_front #(
  parameter int MAX_FRAMES   = ssd_pkg::DEF_MAX_FRAMES,
  parameter int IMAGE_WIDTH  = ssd_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = ssd_pkg::DEF_IMAGE_HEIGHT,
  parameter int QDEPTH       = ssd_pkg::MID_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         pixel_x,
  input  wire logic [7:0]         pixel_y,
  input  wire logic [23:0]        rgb,
  input  wire logic               sof,
  input  wire ssd_pkg::cfg_t      cfg,
  input  wire logic               q_pop,
  output logic                    q_push,
  output ssd_pkg::mid_item_t      q_data
);

  import ssd_pkg::*;

  localparam int LF     = FRONT_STAGES;
  localparam int SLOT_W = $clog2(MAX_FRAMES);
  localparam int HELD_W = $clog2(MAX_FRAMES + 1);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  logic [7:0] xmod_tbl [256];
  logic [7:0] ymod_tbl [256];

  for (genvar i = 0; i < 256; i++) begin : g_mod
    assign xmod_tbl[i] = 8'(i % IMAGE_WIDTH);
    assign ymod_tbl[i] = 8'(i % IMAGE_HEIGHT);
  end

  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [HELD_W-1:0] held_r, held_nxt, limit;
  logic [HELD_W:0]   held_inc;
  logic              acc, new_frame;
  logic [CNT_W-1:0]  cnt_r;
  logic [7:0]        xm, ym;

  logic [LF-1:0]     v_r;
  mid_item_t         it_r [LF];
  mid_item_t         st1, stl;
  logic [7:0]        dx_r, dy_r;
  logic [15:0]       dx2_r, dy2_r;
  root_t             rt_r [ROOT_STEPS+1];

  assign acc = push && !full;
  assign full = (cnt_r >= CNT_W'(QDEPTH));
  assign xm = xmod_tbl[pixel_x];
  assign ym = ymod_tbl[pixel_y];

  always_comb begin
    if (cfg.limit == 7'd0) begin
      limit = HELD_W'(1);
    end else if (32'(cfg.limit) > 32'(MAX_FRAMES)) begin
      limit = HELD_W'(MAX_FRAMES);
    end else begin
      limit = HELD_W'(cfg.limit);
    end
    new_frame = sof || (held_r == '0);
    held_inc  = {1'b0, held_r} + 1'b1;
    head_nxt  = head_r;
    held_nxt  = held_r;
    if (new_frame) begin
      if (held_r != '0) begin
        head_nxt = (head_r == SLOT_W'(MAX_FRAMES - 1)) ? '0 : head_r + 1'b1;
      end
      held_nxt = (held_inc > {1'b0, limit}) ? limit : held_inc[HELD_W-1:0];
    end
  end

  always_comb begin
    // linear delay
    st1       = it_r[0];
    st1.delay = DELAY_W'(((cfg.mode == MODE_VERT) ? it_r[0].y : it_r[0].x) * cfg.inv);
    // radial delay, q.4 distance scaled back to q.12
    stl       = it_r[LF-2];
    if (cfg.mode != MODE_HORIZ && cfg.mode != MODE_VERT) begin
      stl.delay = DELAY_W'((32'(rt_r[ROOT_STEPS].root[ROOT_W-1:0]) * 32'(cfg.inv)) >> 4);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      held_r <= '0;
      cnt_r  <= '0;
      v_r    <= '0;
    end else begin
      if (acc) begin
        head_r <= head_nxt;
        held_r <= held_nxt;
      end
      cnt_r <= cnt_r + CNT_W'(acc) - CNT_W'(q_pop);
      v_r   <= {v_r[LF-2:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    it_r[0].x     <= xm;
    it_r[0].y     <= ym;
    it_r[0].rgb   <= rgb;
    it_r[0].head  <= SLOT_WMAX'(head_nxt);
    it_r[0].last  <= SLOT_WMAX'(held_nxt - 1'b1);
    it_r[0].delay <= '0;
    dx_r <= (xm > cfg.cx) ? xm - cfg.cx : cfg.cx - xm;
    dy_r <= (ym > cfg.cy) ? ym - cfg.cy : cfg.cy - ym;
    it_r[1] <= st1;
    for (int s = 2; s < LF - 1; s++) begin
      it_r[s] <= it_r[s-1];
    end
    it_r[LF-1] <= stl;
    dx2_r <= dx_r * dx_r;
    dy2_r <= dy_r * dy_r;
    rt_r[0].rem  <= (SQ_W+1)'({1'b0, dx2_r} + {1'b0, dy2_r}) << 8;
    rt_r[0].root <= '0;
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    always_ff @(posedge clk) begin
      rt_r[k+1] <= root_step(rt_r[k], (SQ_W+1)'(1) << (2 * (ROOT_STEPS - 1 - k)));
    end
  end

  assign q_push = v_r[LF-1];
  assign q_data = it_r[LF-1];

endmodule

`default_nettype wire

// ===== rtl/core/ssd_back.sv =====
// ----------------------------------------------------------------------------
// ssd_back
// stores the pixel, reads the two neighbouring frames and blends them
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_back #(
  parameter int MAX_FRAMES   = ssd_pkg::DEF_MAX_FRAMES,
  parameter int IMAGE_WIDTH  = ssd_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = ssd_pkg::DEF_IMAGE_HEIGHT,
  parameter int ODEPTH       = ssd_pkg::OUT_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire ssd_pkg::mid_item_t q_data,
  output logic                    q_pop,
  input  wire logic               o_pop,
  output logic                    o_push,
  output ssd_pkg::out_item_t      o_data
);

  import ssd_pkg::*;

  localparam int     SLOT_W    = $clog2(MAX_FRAMES);
  localparam longint FRAME_PIX = longint'(IMAGE_WIDTH) * longint'(IMAGE_HEIGHT);
  localparam longint DEPTH     = longint'(MAX_FRAMES) * FRAME_PIX;
  localparam int     PIX_W     = (FRAME_PIX > 1) ? $clog2(FRAME_PIX) : 1;
  localparam int     ADDR_W    = $clog2(DEPTH);
  localparam int     CNT_W     = $clog2(ODEPTH + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic [BACK_STAGES-1:0] v_r;

  mid_item_t         b0_r;
  logic [SLOT_W-1:0] b1_i0_r, b1_i1_r, b1_head_r;
  logic [PIX_W-1:0]  b1_pix_r;
  logic [ADDR_W-1:0] b2_a0_r, b2_a1_r, b2_wa_r;
  logic              b2_byp0_r, b2_byp1_r, b3_byp0_r, b3_byp1_r;
  logic [FRAC_W-1:0] b1_frac_r, b2_frac_r, b3_frac_r;
  logic [23:0]       b1_rgb_r, b2_rgb_r, b3_rgb_r;
  logic [23:0]       rd0, rd1, c0, c1;
  logic [FRAC_W:0]   w0;
  logic [FRAC_W+8:0] p0_r [3];
  logic [FRAC_W+7:0] p1_r [3];

  logic [IDX_W-1:0]  i0;
  logic [IDX_W:0]    i1, n;
  logic [SLOT_W-1:0] s0, s1;

  assign q_pop = !q_empty && (cnt_r < CNT_W'(ODEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v_r   <= '0;
    end else begin
      cnt_r <= cnt_r + CNT_W'(q_pop) - CNT_W'(o_pop);
      v_r   <= {v_r[BACK_STAGES-2:0], q_pop};
    end
  end

  always_comb begin
    i0 = b0_r.delay[DELAY_W-1:FRAC_W];
    i1 = {1'b0, i0} + 1'b1;
    n  = (IDX_W+1)'(b0_r.last[SLOT_W-1:0]);
    s0 = (b1_head_r >= b1_i0_r) ? b1_head_r - b1_i0_r
                                : SLOT_W'(MAX_FRAMES) + b1_head_r - b1_i0_r;
    s1 = (b1_head_r >= b1_i1_r) ? b1_head_r - b1_i1_r
                                : SLOT_W'(MAX_FRAMES) + b1_head_r - b1_i1_r;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b0_r <= q_data;
    end
    b1_i0_r   <= ({1'b0, i0} > n) ? n[SLOT_W-1:0] : i0[SLOT_W-1:0];
    b1_i1_r   <= (i1 > n) ? n[SLOT_W-1:0] : i1[SLOT_W-1:0];
    b1_head_r <= b0_r.head[SLOT_W-1:0];
    b1_pix_r  <= PIX_W'(64'(b0_r.y) * 64'(IMAGE_WIDTH) + 64'(b0_r.x));
    b1_frac_r <= b0_r.delay[FRAC_W-1:0];
    b1_rgb_r  <= b0_r.rgb;

    b2_a0_r   <= ADDR_W'(64'(s0) * 64'(FRAME_PIX) + 64'(b1_pix_r));
    b2_a1_r   <= ADDR_W'(64'(s1) * 64'(FRAME_PIX) + 64'(b1_pix_r));
    b2_wa_r   <= ADDR_W'(64'(b1_head_r) * 64'(FRAME_PIX) + 64'(b1_pix_r));
    b2_byp0_r <= (b1_i0_r == '0);
    b2_byp1_r <= (b1_i1_r == '0);
    b2_frac_r <= b1_frac_r;
    b2_rgb_r  <= b1_rgb_r;

    b3_byp0_r <= b2_byp0_r;
    b3_byp1_r <= b2_byp1_r;
    b3_frac_r <= b2_frac_r;
    b3_rgb_r  <= b2_rgb_r;

    for (int c = 0; c < 3; c++) begin
      p0_r[c] <= c0[8*c +: 8] * w0;
      p1_r[c] <= c1[8*c +: 8] * b3_frac_r;
    end
  end

  ssd_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (v_r[2]),
    .waddr   (b2_wa_r),
    .wdata   (b2_rgb_r),
    .raddr_a (b2_a0_r),
    .raddr_b (b2_a1_r),
    .rdata_a (rd0),
    .rdata_b (rd1)
  );

  // the newest frame is the pixel just written
  assign c0 = b3_byp0_r ? b3_rgb_r : rd0;
  assign c1 = b3_byp1_r ? b3_rgb_r : rd1;
  assign w0 = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(b3_frac_r);

  assign o_push       = v_r[BACK_STAGES-1];
  assign o_data.blue  = 8'(p0_r[0] >> FRAC_W) + 8'(p1_r[0] >> FRAC_W);
  assign o_data.green = 8'(p0_r[1] >> FRAC_W) + 8'(p1_r[1] >> FRAC_W);
  assign o_data.red   = 8'(p0_r[2] >> FRAC_W) + 8'(p1_r[2] >> FRAC_W);

endmodule

`default_nettype wire
